/* hdl/slip_frame_decoder_defines.svh */
// Assertion macros for the SLIP frame decoder.
// Bodies refer to i_clk and i_rst_n of the including module.
`ifndef SLIP_FRAME_DECODER_DEFINES_SVH
`define SLIP_FRAME_DECODER_DEFINES_SVH

// same-cycle implication
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/sfd_pkg.sv */
// Shared constants and types for the SLIP frame decoder.
// No dependencies; used by sfd_stream_if, sfd_ctrl and slip_frame_decoder.
`default_nettype none

package sfd_pkg;

    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 7;
    localparam int DEPTH_DEFAULT = 64;

    localparam logic [LEN_W-1:0]  LIMIT_RESET = 7'd64;

    localparam logic [BYTE_W-1:0] SYM_END     = 8'hC0;
    localparam logic [BYTE_W-1:0] SYM_ESC     = 8'hDB;
    localparam logic [BYTE_W-1:0] SYM_ESC_END = 8'hDC;
    localparam logic [BYTE_W-1:0] SYM_ESC_ESC = 8'hDD;

    // sequencer -> output register
    typedef struct packed {
        logic             load;
        logic             last;
        logic [LEN_W-1:0] length;
    } t_load;

    // sequencer status, for checks
    typedef struct packed {
        logic             busy;
        logic             esc;
        logic [LEN_W-1:0] fill;
    } t_stat;

endpackage

`default_nettype wire

/* hdl/sfd_stream_if.sv */
// Valid/ready channel interfaces for received bytes and decoded frame beats.
// Depends on sfd_pkg.
`default_nettype none

interface sfd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [sfd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_frame_if;
    logic                       valid;
    logic                       ready;
    logic [sfd_pkg::BYTE_W-1:0] frame_byte;
    logic [sfd_pkg::LEN_W-1:0]  frame_length;
    logic                       last_byte;

    modport source (output valid, output frame_byte, output frame_length,
                    output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input frame_length,
                    input last_byte, output ready);
endinterface

`default_nettype wire

/* hdl/sfd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hdl/sfd_ctrl.sv */
// Byte decoder and frame readout sequencer of the SLIP frame decoder.
// Depends on sfd_pkg; drives the frame store RAM ports.
`default_nettype none

module sfd_ctrl #(
    parameter int STORE_DEPTH = sfd_pkg::DEPTH_DEFAULT,
    parameter int AW          = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [sfd_pkg::BYTE_W-1:0] i_byte,
    input  wire logic [sfd_pkg::LEN_W-1:0]  i_limit,
    input  wire logic                       i_out_free,
    output sfd_pkg::t_load                  o_load,
    output sfd_pkg::t_stat                  o_stat,
    output logic                            o_wr_en,
    output logic [AW-1:0]                   o_wr_addr,
    output logic [sfd_pkg::BYTE_W-1:0]      o_wr_data,
    output logic [AW-1:0]                   o_rd_addr
);

    localparam int LW = sfd_pkg::LEN_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(STORE_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;   // read address settles in the RAM
    localparam logic [1:0] ST_SEND = 2'd2;   // read data valid, push one beat

    logic [1:0]    r_state, n_state;
    logic [LW-1:0] r_fill,  n_fill;
    logic          r_esc,   n_esc;
    logic [LW-1:0] r_len,   n_len;
    logic [LW-1:0] r_idx,   n_idx;

    logic [LW-1:0] lim;
    logic [LW-1:0] fresh_fill;
    logic [LW-1:0] base;
    logic          accept;
    logic          esc_seq;

    always_comb begin
        if (i_limit == '0) begin
            lim = LW'(1);
        end else if (i_limit > DEPTH_L) begin
            lim = DEPTH_L;
        end else begin
            lim = i_limit;
        end
    end

    assign accept     = i_valid && (r_state == ST_IDLE);
    assign esc_seq    = r_esc && (i_byte == sfd_pkg::SYM_ESC_END ||
                                  i_byte == sfd_pkg::SYM_ESC_ESC);
    // a bad escape drops the open frame before the byte is handled fresh
    assign fresh_fill = r_esc ? '0 : r_fill;
    assign base       = (fresh_fill >= lim) ? '0 : fresh_fill;

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_esc     = r_esc;
        n_len     = r_len;
        n_idx     = r_idx;
        o_wr_en   = 1'b0;
        o_wr_addr = base[AW-1:0];
        o_wr_data = i_byte;
        o_load    = '0;
        o_load.length = r_len;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_esc = 1'b0;
                    if (esc_seq) begin
                        if (r_fill >= lim) begin
                            n_fill = '0;
                        end else begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = r_fill[AW-1:0];
                            o_wr_data = (i_byte == sfd_pkg::SYM_ESC_END) ?
                                        sfd_pkg::SYM_END : sfd_pkg::SYM_ESC;
                            n_fill    = r_fill + LW'(1);
                        end
                    end else if (i_byte == sfd_pkg::SYM_END) begin
                        n_fill = '0;
                        if (fresh_fill != '0) begin
                            n_len   = fresh_fill;
                            n_idx   = '0;
                            n_state = ST_PREP;
                        end
                    end else if (i_byte == sfd_pkg::SYM_ESC) begin
                        n_esc  = 1'b1;
                        n_fill = base;
                    end else begin
                        o_wr_en = 1'b1;
                        n_fill  = base + LW'(1);
                    end
                end
            end
            ST_PREP: begin
                n_state = ST_SEND;
            end
            ST_SEND: begin
                if (i_out_free) begin
                    o_load.load = 1'b1;
                    o_load.last = (r_idx == r_len - LW'(1));
                    n_idx       = r_idx + LW'(1);
                    n_state     = o_load.last ? ST_IDLE : ST_PREP;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_esc   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_esc   <= n_esc;
        end
        r_len <= n_len;
        r_idx <= n_idx;
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_rd_addr   = r_idx[AW-1:0];
    assign o_stat.busy = (r_state != ST_IDLE);
    assign o_stat.esc  = r_esc;
    assign o_stat.fill = r_fill;

endmodule

`default_nettype wire

/* hdl/slip_frame_decoder.sv */
// Top level of the SLIP (RFC 1055) receive-side frame decoder.
// Depends on sfd_pkg, sfd_stream_if, sfd_ram, sfd_ctrl and the defines header.
//
//  channel   dir  beat payload                          handshake
//  i_rx      in   rx_byte[7:0]                          valid/ready
//  o_frame   out  frame_byte[7:0], frame_length[6:0],   valid/ready
//                 last_byte
//  cfg       in   i_cfg_wdata[6:0] -> frame_limit       i_cfg_we, no stall
//
// A byte that does not close a frame leaves i_rx ready.
// A closing END starts the readout, which reuses the one read port of the
// frame store: ST_PREP presents each byte's address, ST_SEND pushes its beat.
// o_frame stalls hold the readout in place; i_rx is not ready until the last
// beat sits in the output register. Reset (synchronous, active low) empties
// the frame, clears the escape flag and sets frame_limit to 64.
`default_nettype none

`include "slip_frame_decoder_defines.svh"

module slip_frame_decoder #(
    parameter int STORE_DEPTH = sfd_pkg::DEPTH_DEFAULT
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    sfd_byte_if.sink                       i_rx,
    sfd_frame_if.source                    o_frame,
    input  wire logic                      i_cfg_we,
    input  wire logic [sfd_pkg::LEN_W-1:0] i_cfg_wdata
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int BW = sfd_pkg::BYTE_W;
    localparam int LW = sfd_pkg::LEN_W;

    // configuration
    logic [LW-1:0] r_frame_limit;

    // output register
    logic          r_out_valid;
    logic [BW-1:0] r_out_byte;
    logic [LW-1:0] r_out_len;
    logic          r_out_last;

    // store ports and sequencer links
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [BW-1:0]  wr_data;
    logic [AW-1:0]  rd_addr;
    logic [BW-1:0]  rd_data;
    logic           out_free;
    sfd_pkg::t_load load;
    sfd_pkg::t_stat stat;

    // terms for the checks
    logic           rx_beat;
    logic           last_load;
    logic           end_on_open;
    logic           rd_started;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= sfd_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_frame_limit <= i_cfg_wdata;
        end
    end

    // Frame store: written on accepted data bytes; readout uses its read data.
    sfd_ram #(
        .WIDTH (BW),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sfd_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_rx.valid),
        .o_ready    (i_rx.ready),
        .i_byte     (i_rx.rx_byte),
        .i_limit    (r_frame_limit),
        .i_out_free (out_free),
        .o_load     (load),
        .o_stat     (stat),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_addr  (rd_addr)
    );

    // Output register can take a new beat when empty or when drained now.
    assign out_free = !r_out_valid || o_frame.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load.load) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
        if (load.load) begin
            r_out_byte <= rd_data;
            r_out_len  <= load.length;
            r_out_last <= load.last;
        end
    end

    assign o_frame.valid        = r_out_valid;
    assign o_frame.frame_byte   = r_out_byte;
    assign o_frame.frame_length = r_out_len;
    assign o_frame.last_byte    = r_out_last;

    // Checks
    assign rx_beat     = i_rx.valid && i_rx.ready;
    assign last_load   = load.load && load.last;
    assign end_on_open = rx_beat && !stat.esc && stat.fill != '0 &&
                         i_rx.rx_byte == sfd_pkg::SYM_END;
    assign rd_started  = stat.busy && stat.fill == '0;

    `SFD_ASSERT_NEXT(a_last_frees_input, last_load, i_rx.ready, "readout kept input blocked")
    `SFD_ASSERT_NOW(a_len_nonzero, r_out_valid, r_out_len != '0, "zero frame length")
    `SFD_ASSERT_NEXT(a_end_starts_readout, end_on_open, rd_started, "END left frame open")

endmodule

`default_nettype wire
